>>> design/zpcf_pkg.sv
// Shared types, constants and helpers of the zero-padded 2D correlation filter.
// No dependencies; every other design file imports this package.
package zpcf_pkg;

    // Sizes of the filter
    localparam int MAX_KERNEL  = 15;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CHANNELS    = 3;
    localparam int COEF_COUNT  = MAX_KERNEL * MAX_KERNEL;

    // Field widths
    localparam int KDIM_W      = 4;
    localparam int DIM_W       = 11;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 11;
    localparam int COEF_W      = 18;
    localparam int PIX_W       = 8;
    localparam int PIXEL_W     = PIX_W * CHANNELS;
    localparam int OUT_W       = 24;
    localparam int OUT_ROW_W   = 10;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 96;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;

    // Line store: one bank of MAX_WIDTH words per kernel row
    localparam int LINE_DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);

    // Arithmetic widths: 8u x 18s product, sum over one kernel row, sum over all rows
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    localparam int PS_W        = PROD_W + 4;
    localparam int ACC_W       = PS_W + 5;

    // Reciprocal of 15 for an 8-bit coefficient index: (idx * 137) >> 11
    localparam int RECIP_15    = 137;
    localparam int RECIP_SHIFT = 11;

    // Request kinds
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_PAD   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Coefficient write broadcast to the cells
    typedef struct packed {
        logic                     we;
        logic [KDIM_W-1:0]        row;
        logic [KDIM_W-1:0]        col;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

    // One window sample broadcast to the cells, with its kernel row
    typedef struct packed {
        logic [KDIM_W-1:0]  row;
        logic [PIXEL_W-1:0] pix;
    } tap_t;

    typedef logic [CHANNELS-1:0][PS_W-1:0] psum_vec_t;

    // Round to nearest (ties up) from Q.16 to Q.8 and saturate to 24 bits
    function automatic logic [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        localparam logic signed [ACC_W-9:0] Q_HI = (ACC_W-8)'(8388607);
        localparam logic signed [ACC_W-9:0] Q_LO = -(ACC_W-8)'(8388608);
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-9:0] q;
        v = s + ACC_W'(128);
        q = v[ACC_W-1:8];
        if (q > Q_HI)
            return OUT_W'(Q_HI);
        else if (q < Q_LO)
            return OUT_W'(Q_LO);
        else
            return q[OUT_W-1:0];
    endfunction

endpackage

>>> design/zpcf_line_mem.sv
// Line store of the correlation filter: MAX_KERNEL banks of one image row each.
// One write port, one registered read port. Depends on zpcf_pkg.
module zpcf_line_mem
    import zpcf_pkg::*;
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [LINE_ADDR_W-1:0] wr_addr,
    input  logic [PIXEL_W-1:0]     wr_data,
    input  logic                   rd_en,
    input  logic [LINE_ADDR_W-1:0] rd_addr,
    output logic [PIXEL_W-1:0]     rd_data
);

    logic [PIXEL_W-1:0] mem [LINE_DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // Write a pixel, read one window sample
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/zpcf_cell.sv
// One multiply-accumulate cell of the transposed correlation chain.
// Holds one kernel column of coefficients. Depends on zpcf_pkg.
module zpcf_cell
    import zpcf_pkg::*;
(
    input  logic              clk,
    input  logic [KDIM_W-1:0] col_id,
    input  logic [KDIM_W-1:0] kernel_cols,
    input  coef_wr_t          coef_wr,
    input  tap_t              tap,
    input  psum_vec_t         ps_in,
    output psum_vec_t         ps_out
);

    logic signed [COEF_W-1:0] coef_reg [MAX_KERNEL];
    psum_vec_t                ps_reg;
    psum_vec_t                ps_next;
    logic                     active;

    // Store this column's coefficients, one per kernel row
    always_ff @(posedge clk)
    begin
        if (coef_wr.we && coef_wr.col == col_id)
        begin
            coef_reg[coef_wr.row] <= coef_wr.value;
        end
    end

    // Columns beyond the kernel width add nothing
    assign active = (col_id < kernel_cols);

    // Add this cell's product to the partial sum from the left neighbor
    always_comb
    begin
        logic signed [COEF_W-1:0] coef_sel;
        logic signed [PROD_W-1:0] prod;
        coef_sel = coef_reg[tap.row];
        ps_next  = ps_in;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            prod = $signed({1'b0, tap.pix[ch*PIX_W +: PIX_W]}) * coef_sel;
            if (active)
            begin
                ps_next[ch] = PS_W'($signed(ps_in[ch]) + PS_W'(prod));
            end
        end
    end

    // Hand the partial sum to the right neighbor
    always_ff @(posedge clk)
    begin
        ps_reg <= ps_next;
    end

    assign ps_out = ps_reg;

endmodule

>>> design/zero_padded_2d_correlation_filter.sv
// Top level of the zero-padded 2D correlation filter: sequencer, line store, cell chain.
// Depends on zpcf_pkg, zpcf_line_mem and zpcf_cell.
//
// Flow: a pixel in passthrough mode (an even kernel dimension) yields one result. In filter
// mode each result that a pixel or pad request releases (up to eight at a row end) is
// computed by feeding the 15-cell multiply-accumulate chain one line-store word per cycle,
// 15 words per kernel row, followed by the pipeline registers and the output register.
// The next request is accepted once the last result of the current one sits in the
// output register. The line store needs no clearing after reset.
module zero_padded_2d_correlation_filter
    import zpcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] coef_index, [25:8] coef_value, [33:26] sample_red, [41:34] sample_green,
    // [49:42] sample_blue, [55:50] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [23:0] filtered_red, [47:24] filtered_green, [71:48] filtered_blue,
    // [81:72] out_row, [91:82] out_col, [95:92] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // [0] frame_done
    output logic [0:0]            m_tuser,
    // Register writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    // Registers
    logic [KDIM_W-1:0] krows_reg, kcols_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;

    // Frame position
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [KDIM_W-1:0] bank_reg, bank_next;

    // Current request
    logic               pt_reg, pt_next;
    logic [PIXEL_W-1:0] pt_pix_reg, pt_pix_next;
    logic [ROW_W-1:0]   orow_reg, orow_next;
    logic [COL_W-1:0]   oc_reg, oc_next;
    logic [COL_W-1:0]   oc_last_reg, oc_last_next;
    logic [KDIM_W-1:0]  bank0_reg, bank0_next;
    logic signed [11:0] y0_reg, y0_next;

    // Window sequencer
    logic [KDIM_W-1:0]  tap_i_reg, tap_i_next;
    logic [KDIM_W-1:0]  tap_m_reg, tap_m_next;
    logic [KDIM_W-1:0]  bank_y_reg, bank_y_next;
    logic signed [11:0] y_reg, y_next;

    // Pipeline flags
    logic              ok_d1_reg, end_d1_reg, last_d1_reg, end_d2_reg, last_d2_reg;
    logic [KDIM_W-1:0] m_d1_reg;

    logic signed [ACC_W-1:0] acc_reg [CHANNELS];
    logic signed [ACC_W-1:0] acc_next [CHANNELS];

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    // Derived settings
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [DIM_W:0]    h_plus;
    logic [2:0]        rv, rh;
    logic              pass_mode;

    // Request decode
    op_t                op;
    logic               in_take;
    logic [PIXEL_W-1:0] samples;
    logic [7:0]         coef_idx;
    logic [15:0]        idx_mul;
    logic [7:0]         idx_col;
    coef_wr_t           coef_wr;

    // Accept-time position math
    logic               wrap;
    logic [ROW_W-1:0]   r_cur;
    logic [COL_W-1:0]   c_cur;
    logic [KDIM_W-1:0]  b_cur;
    logic               c_last_col, emit_any;
    logic [COL_W-1:0]   first_col;
    logic [4:0]         bsum;
    logic [KDIM_W-1:0]  bank0_calc;
    logic signed [11:0] y0_calc;
    logic               real_pix;

    // Feed and output control
    logic               issue, row_end, feed_last, tap_ok;
    logic signed [11:0] x_pos;
    logic               out_free, out_load, run_end;

    // Line store and chain
    logic                   line_we;
    logic [LINE_ADDR_W-1:0] line_waddr, line_raddr;
    logic [PIXEL_W-1:0]     line_wdata, line_rdata;
    tap_t                   tap;
    psum_vec_t              chain_ps [MAX_KERNEL+1];

    // Clamp the image size and split the kernel
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign pass_mode = !krows_reg[0] || !kcols_reg[0];
    assign rv        = krows_reg[3:1];
    assign rh        = kcols_reg[3:1];
    assign h_plus    = {1'b0, h_eff} + (DIM_W+1)'(rv);

    // Decode the request
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign coef_idx = s_tdata[7:0];
    assign samples  = s_tdata[49:26];

    // Split the coefficient index into kernel row and column
    assign idx_mul = 16'(coef_idx) * 16'(RECIP_15);
    assign idx_col = coef_idx - 8'(idx_mul[14:RECIP_SHIFT]) * 8'(MAX_KERNEL);

    always_comb
    begin
        coef_wr.we    = in_take && (op == OP_LOAD) && (coef_idx < 8'(COEF_COUNT));
        coef_wr.row   = idx_mul[14:RECIP_SHIFT];
        coef_wr.col   = idx_col[KDIM_W-1:0];
        coef_wr.value = $signed(s_tdata[25:8]);
    end

    // Position of this request and the results it releases
    always_comb
    begin
        wrap       = ({1'b0, row_reg} >= h_plus) || ({1'b0, col_reg} >= w_eff);
        r_cur      = wrap ? '0 : row_reg;
        c_cur      = wrap ? '0 : col_reg;
        b_cur      = wrap ? '0 : bank_reg;
        real_pix   = (op == OP_PIXEL) && (r_cur < h_eff);
        c_last_col = ({1'b0, c_cur} == (w_eff - DIM_W'(1)));
        first_col  = (c_cur >= COL_W'(rh)) ? (c_cur - COL_W'(rh)) : '0;
        emit_any   = (r_cur >= ROW_W'(rv)) && (c_last_col || (c_cur >= COL_W'(rh)));
        bsum       = {1'b0, b_cur} + 5'(MAX_KERNEL) - {1'b0, rv, 1'b0};
        bank0_calc = (bsum >= 5'(MAX_KERNEL)) ? KDIM_W'(bsum - 5'(MAX_KERNEL))
                                               : bsum[KDIM_W-1:0];
        y0_calc    = $signed({1'b0, r_cur}) - $signed({8'b0, rv, 1'b0});
    end

    // Store the incoming pixel, or zero for a pad row
    assign line_we    = in_take && !pass_mode && (op == OP_PIXEL || op == OP_PAD);
    assign line_waddr = {b_cur, c_cur};
    assign line_wdata = real_pix ? samples : '0;

    // Window tap address and validity
    assign issue     = (state_reg == ST_FEED);
    assign row_end   = (tap_i_reg == KDIM_W'(MAX_KERNEL-1));
    assign feed_last = issue && row_end && (tap_m_reg == krows_reg - KDIM_W'(1));
    assign x_pos     = $signed({2'b0, oc_reg}) - $signed({9'b0, rh})
                     + $signed({8'b0, tap_i_reg});
    assign tap_ok    = (tap_i_reg < kcols_reg)
                     && !x_pos[11] && (x_pos < $signed({1'b0, w_eff}))
                     && !y_reg[11] && (y_reg < $signed({1'b0, h_eff}));
    assign line_raddr = {bank_y_reg, x_pos[COL_W-1:0]};

    zpcf_line_mem u_line_mem (
        .clk     (clk),
        .wr_en   (line_we),
        .wr_addr (line_waddr),
        .wr_data (line_wdata),
        .rd_en   (issue),
        .rd_addr (line_raddr),
        .rd_data (line_rdata)
    );

    // Broadcast the sample, zero outside the image
    assign tap.pix    = ok_d1_reg ? line_rdata : '0;
    assign tap.row    = m_d1_reg;
    assign chain_ps[0] = '0;

    for (genvar i = 0; i < MAX_KERNEL; i++)
    begin : g_cell
        zpcf_cell u_cell (
            .clk         (clk),
            .col_id      (KDIM_W'(i)),
            .kernel_cols (kcols_reg),
            .coef_wr     (coef_wr),
            .tap         (tap),
            .ps_in       (chain_ps[i]),
            .ps_out      (chain_ps[i+1])
        );
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign run_end  = pt_reg || (oc_reg == oc_last_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (op == OP_PIXEL || op == OP_PAD))
                begin
                    if (pass_mode)
                    begin
                        if (op == OP_PIXEL)
                            state_next = ST_OUT;
                    end
                    else if (emit_any)
                    begin
                        state_next = ST_FEED;
                    end
                end
            end
            ST_FEED:
            begin
                if (feed_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (last_d2_reg)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = run_end ? ST_IDLE : ST_FEED;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        logic [DIM_W-1:0] c1;
        logic [DIM_W:0]   r1;
        row_next       = row_reg;
        col_next       = col_reg;
        bank_next      = bank_reg;
        pt_next        = pt_reg;
        pt_pix_next    = pt_pix_reg;
        orow_next      = orow_reg;
        oc_next        = oc_reg;
        oc_last_next   = oc_last_reg;
        bank0_next     = bank0_reg;
        y0_next        = y0_reg;
        tap_i_next     = tap_i_reg;
        tap_m_next     = tap_m_reg;
        bank_y_next    = bank_y_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        c1             = '0;
        r1             = '0;

        // Take a pixel or pad request
        if (in_take && (op == OP_PIXEL || op == OP_PAD))
        begin
            if (pass_mode)
            begin
                if (op == OP_PIXEL)
                begin
                    pt_next      = 1'b1;
                    pt_pix_next  = samples;
                    orow_next    = row_reg;
                    oc_next      = col_reg;
                    oc_last_next = col_reg;
                    c1 = {1'b0, col_reg} + DIM_W'(1);
                    if (c1 >= w_eff)
                    begin
                        col_next = '0;
                        r1 = {1'b0, row_reg} + (DIM_W+1)'(1);
                        row_next = (r1 >= {1'b0, h_eff}) ? '0 : r1[ROW_W-1:0];
                    end
                    else
                    begin
                        col_next = c1[COL_W-1:0];
                    end
                end
            end
            else
            begin
                pt_next      = 1'b0;
                orow_next    = r_cur - ROW_W'(rv);
                oc_next      = first_col;
                oc_last_next = c_last_col ? c_cur : first_col;
                bank0_next   = bank0_calc;
                y0_next      = y0_calc;
                tap_i_next   = '0;
                tap_m_next   = '0;
                bank_y_next  = bank0_calc;
                y_next       = y0_calc;
                for (int ch = 0; ch < CHANNELS; ch++)
                    acc_next[ch] = '0;
                c1 = {1'b0, c_cur} + DIM_W'(1);
                if (c1 >= w_eff)
                begin
                    col_next = '0;
                    r1 = {1'b0, r_cur} + (DIM_W+1)'(1);
                    if (r1 >= h_plus)
                    begin
                        row_next  = '0;
                        bank_next = '0;
                    end
                    else
                    begin
                        row_next  = r1[ROW_W-1:0];
                        bank_next = (b_cur == KDIM_W'(MAX_KERNEL-1)) ? '0
                                                                      : b_cur + KDIM_W'(1);
                    end
                end
                else
                begin
                    col_next  = c1[COL_W-1:0];
                    row_next  = r_cur;
                    bank_next = b_cur;
                end
            end
        end

        // Walk the window: 15 taps per kernel row
        if (issue)
        begin
            if (row_end)
            begin
                tap_i_next  = '0;
                tap_m_next  = tap_m_reg + KDIM_W'(1);
                bank_y_next = (bank_y_reg == KDIM_W'(MAX_KERNEL-1)) ? '0
                                                                     : bank_y_reg + KDIM_W'(1);
                y_next      = y_reg + 12'sd1;
            end
            else
            begin
                tap_i_next = tap_i_reg + KDIM_W'(1);
            end
        end

        // Add each finished kernel row into the result
        if (end_d2_reg)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
                acc_next[ch] = acc_reg[ch] + ACC_W'($signed(chain_ps[MAX_KERNEL][ch]));
        end

        // Load the output register, then start the next result if any
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                out_data_next[ch*OUT_W +: OUT_W] = pt_reg
                    ? {8'h00, pt_pix_reg[ch*PIX_W +: PIX_W], 8'h00}
                    : round_sat(acc_reg[ch]);
            end
            out_data_next[CHANNELS*OUT_W +: OUT_ROW_W] = orow_reg[OUT_ROW_W-1:0];
            out_data_next[CHANNELS*OUT_W+OUT_ROW_W +: COL_W] = oc_reg;
            out_last_next = run_end;
            out_done_next = (orow_reg == ROW_W'(h_eff - DIM_W'(1)))
                         && ({1'b0, oc_reg} == (w_eff - DIM_W'(1)));
            if (!run_end)
            begin
                oc_next     = oc_reg + COL_W'(1);
                tap_i_next  = '0;
                tap_m_next  = '0;
                bank_y_next = bank0_reg;
                y_next      = y0_reg;
                for (int ch = 0; ch < CHANNELS; ch++)
                    acc_next[ch] = '0;
            end
        end

        // A register write restarts the frame
        if (cfg_we)
        begin
            row_next  = '0;
            col_next  = '0;
            bank_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            krows_reg     <= KDIM_W'(1);
            kcols_reg     <= KDIM_W'(1);
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= '0;
            out_valid_reg <= 1'b0;
            ok_d1_reg     <= 1'b0;
            end_d1_reg    <= 1'b0;
            last_d1_reg   <= 1'b0;
            end_d2_reg    <= 1'b0;
            last_d2_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
            ok_d1_reg     <= issue && tap_ok;
            end_d1_reg    <= issue && row_end;
            last_d1_reg   <= feed_last;
            end_d2_reg    <= end_d1_reg;
            last_d2_reg   <= last_d1_reg;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KERNEL_ROWS:  krows_reg  <= cfg_data[KDIM_W-1:0];
                    REG_KERNEL_COLS:  kcols_reg  <= cfg_data[KDIM_W-1:0];
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pt_reg       <= pt_next;
        pt_pix_reg   <= pt_pix_next;
        orow_reg     <= orow_next;
        oc_reg       <= oc_next;
        oc_last_reg  <= oc_last_next;
        bank0_reg    <= bank0_next;
        y0_reg       <= y0_next;
        tap_i_reg    <= tap_i_next;
        tap_m_reg    <= tap_m_next;
        bank_y_reg   <= bank_y_next;
        y_reg        <= y_next;
        m_d1_reg     <= tap_m_reg;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_done_reg;

    // Column position stays inside the image
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < w_eff))
        else $error("column position beyond image width");

    // Window walk stays inside the line banks
    a_feed_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FEED) |->
            (bank_y_reg <= KDIM_W'(MAX_KERNEL-1)) && (tap_i_reg <= KDIM_W'(MAX_KERNEL-1)))
        else $error("window walk out of bounds");

    // The final kernel row lands only while waiting for it
    a_final_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        last_d2_reg |-> (state_reg == ST_WAIT))
        else $error("final row sum arrived outside the wait state");

    // A new result comes only from the output state
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule

>>> bench/tb_zero_padded_2d_correlation_filter.sv
// Self-checking bench for the zero-padded 2D correlation filter: a directed table, then
// random frames over many kernel and image settings, checked against an in-bench predictor.
// Depends on zpcf_pkg and the zero_padded_2d_correlation_filter design.
`timescale 1ns / 1ps

module tb_zero_padded_2d_correlation_filter;
    import zpcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 1500;
    localparam int COEF_MAX       = 131071;
    localparam int COEF_MIN       = -131072;

    typedef struct packed {
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] blue;
        logic [9:0]              row;
        logic [9:0]              col;
        logic                    last;
        logic                    done;
    } pixel_result_t;

    // One line of the directed table: a register write or a request, optional typed result
    typedef struct {
        bit   is_cfg;
        int   reg_idx;
        int   value;
        op_t  op;
        int   coef_idx;
        int   coef;
        int   red;
        int   green;
        int   blue;
        bit   typed;
        int   exp_red;
        int   exp_green;
        int   exp_blue;
        int   exp_row;
        int   exp_col;
        bit   exp_last;
        bit   exp_done;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // Predictor state
    pixel_result_t expected_q[$];
    int            coef_mem[COEF_COUNT];
    bit            coef_written[COEF_COUNT];
    logic [7:0]    line_mem[MAX_KERNEL][MAX_WIDTH][3];
    int            cur_row;
    int            cur_col;
    int            reg_kr;
    int            reg_kc;
    int            reg_w;
    int            reg_h;

    int            failures;
    int            idle_mode;
    bit            long_hold;
    int            total_items;
    int            idle_cycles;
    stim_row_t     directed[$];

    zero_padded_2d_correlation_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Round Q.16 to Q.8, ties up, and clip to 24 bits
    function automatic logic signed [OUT_W-1:0] round_q8(longint acc);
        longint q;
        q = (acc + 128) >>> 8;
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[OUT_W-1:0];
    endfunction

    function automatic longint correlate_at(int orow, int ocol, int ch, int kr, int kc,
                                            int w, int h);
        longint acc;
        int     y;
        int     x;
        acc = 0;
        for (int m = 0; m < kr; m++)
        begin
            y = orow - (kr - 1) / 2 + m;
            if (y < 0 || y >= h)
                continue;
            for (int n = 0; n < kc; n++)
            begin
                x = ocol - (kc - 1) / 2 + n;
                if (x < 0 || x >= w)
                    continue;
                acc += longint'(line_mem[y % MAX_KERNEL][x][ch]) *
                       longint'(coef_mem[m * MAX_KERNEL + n]);
            end
        end
        return acc;
    endfunction

    // Advance the predictor by one accepted request and queue the results it releases
    function automatic void predict_request(op_t op, logic [IN_DATA_W-1:0] d);
        int            kr;
        int            kc;
        int            w;
        int            h;
        int            r;
        int            c;
        int            rv;
        int            rh;
        int            first_col;
        int            last_col;
        bit            any;
        bit            is_image;
        logic [7:0]    smp[3];
        pixel_result_t res;
        smp[0] = d[33:26];
        smp[1] = d[41:34];
        smp[2] = d[49:42];
        if (op == OP_LOAD)
        begin
            if (d[7:0] < COEF_COUNT)
            begin
                coef_mem[d[7:0]]     = int'($signed(d[25:8]));
                coef_written[d[7:0]] = 1'b1;
            end
            return;
        end
        if (op == OP_NONE)
            return;
        kr = reg_kr > MAX_KERNEL ? MAX_KERNEL : reg_kr;
        kc = reg_kc > MAX_KERNEL ? MAX_KERNEL : reg_kc;
        w  = reg_w < 1 ? 1 : (reg_w > MAX_WIDTH ? MAX_WIDTH : reg_w);
        h  = reg_h < 1 ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
        r  = cur_row;
        c  = cur_col;
        // Passthrough: an even dimension
        if (kr % 2 == 0 || kc % 2 == 0)
        begin
            if (op == OP_PAD)
                return;
            res.red   = OUT_W'(int'(smp[0]) * 256);
            res.green = OUT_W'(int'(smp[1]) * 256);
            res.blue  = OUT_W'(int'(smp[2]) * 256);
            res.row   = r[9:0];
            res.col   = c[9:0];
            res.last  = 1'b1;
            res.done  = (r == h - 1 && c == w - 1);
            expected_q.push_back(res);
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            cur_row = r;
            cur_col = c;
            return;
        end
        rv = (kr - 1) / 2;
        rh = (kc - 1) / 2;
        if (r >= h + rv || c >= w)
        begin
            r = 0;
            c = 0;
        end
        is_image = (op == OP_PIXEL) && r < h;
        for (int ch = 0; ch < 3; ch++)
            line_mem[r % MAX_KERNEL][c][ch] = is_image ? smp[ch] : 8'd0;
        if (r >= rv)
        begin
            any = 1'b1;
            if (c == w - 1)
            begin
                first_col = c >= rh ? c - rh : 0;
                last_col  = c;
            end
            else if (c >= rh)
            begin
                first_col = c - rh;
                last_col  = first_col;
            end
            else
            begin
                first_col = 0;
                last_col  = 0;
                any       = 1'b0;
            end
            if (any)
            begin
                for (int oc = first_col; oc <= last_col; oc++)
                begin
                    res.red   = round_q8(correlate_at(r - rv, oc, 0, kr, kc, w, h));
                    res.green = round_q8(correlate_at(r - rv, oc, 1, kr, kc, w, h));
                    res.blue  = round_q8(correlate_at(r - rv, oc, 2, kr, kc, w, h));
                    res.row   = 10'(r - rv);
                    res.col   = oc[9:0];
                    res.last  = (oc == last_col);
                    res.done  = (r - rv == h - 1 && oc == w - 1);
                    expected_q.push_back(res);
                end
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h + rv)
                r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    // Offer one request and hold it until accepted; enters and leaves at a falling edge
    task automatic send_request(op_t op, int idx, int coef, int sr, int sg, int sb);
        logic [IN_DATA_W-1:0] d;
        d        = '0;
        d[7:0]   = idx[7:0];
        d[25:8]  = coef[17:0];
        d[33:26] = sr[7:0];
        d[41:34] = sg[7:0];
        d[49:42] = sb[7:0];
        while ((idle_mode == 0 && $urandom_range(0, 99) < 12) ||
               (idle_mode == 1 && $urandom_range(0, 99) < 73))
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tuser  = op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(op, d);
        total_items++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Hold off until every expected result is out, then let in-flight work finish
    task automatic wait_drained();
        int lat;
        while (expected_q.size() != 0)
            @(posedge clk);
        lat = ((reg_kr == 0 ? 1 : reg_kr) * 15 + 3) * 8 + 8;
        repeat (lat) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_W-1:0];
        @(posedge clk);
        case (idx)
            REG_KERNEL_ROWS:  reg_kr = value & 15;
            REG_KERNEL_COLS:  reg_kc = value & 15;
            REG_IMAGE_WIDTH:  reg_w  = value & 2047;
            REG_IMAGE_HEIGHT: reg_h  = value & 2047;
            default: ;
        endcase
        cur_row = 0;
        cur_col = 0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(int kr, int kc, int w, int h);
        wait_drained();
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kc);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Load the kernel in use: every tap when forced, else only taps never written
    task automatic load_kernel(bit force_all, int value);
        int idx;
        for (int m = 0; m < reg_kr; m++)
            for (int n = 0; n < reg_kc; n++)
            begin
                idx = m * MAX_KERNEL + n;
                if (force_all)
                    send_request(OP_LOAD, idx, value, 0, 0, 0);
                else if (!coef_written[idx])
                    send_request(OP_LOAD, idx, $urandom_range(0, 262143),
                                 $urandom_range(0, 255), $urandom_range(0, 255), 0);
            end
    endtask

    // Stream positional requests; noise adds stray ops, bad loads, tap reloads and swaps
    task automatic stream_frame(int count, bit noise, bit full_scale);
        op_t op;
        int  pick;
        int  hh;
        bit  pass;
        hh   = reg_h < 1 ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
        pass = (reg_kr % 2 == 0) || (reg_kc % 2 == 0);
        for (int i = 0; i < count; i++)
        begin
            if (noise && $urandom_range(0, 99) < 8)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    send_request(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 262143),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255));
                else if (pick == 1)
                    send_request(OP_LOAD, $urandom_range(COEF_COUNT, 255),
                                 $urandom_range(0, 262143), 0, 0, 0);
                else if (pass)
                    send_request(OP_PAD, 0, 0, $urandom_range(0, 255), 0, 0);
                else
                    send_request(OP_LOAD, $urandom_range(0, (reg_kr - 1) * MAX_KERNEL),
                                 $urandom_range(0, 262143), 0, 0, 0);
            end
            op = (!pass && cur_row >= hh) ? OP_PAD : OP_PIXEL;
            if (noise && !pass && $urandom_range(0, 99) < 8)
                op = (op == OP_PAD) ? OP_PIXEL : OP_PAD;
            if (full_scale)
                send_request(op, 0, 0, 255, 255, 255);
            else
                send_request(op, $urandom_range(0, 255), $urandom_range(0, 262143),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red   = m_tdata[23:0];
            got.green = m_tdata[47:24];
            got.blue  = m_tdata[71:48];
            got.row   = m_tdata[81:72];
            got.col   = m_tdata[91:82];
            got.last  = m_tlast;
            got.done  = m_tuser[0];
            if (expected_q.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d at (%0d,%0d)", $realtime,
                         got.red, got.green, got.blue, got.row, got.col);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    failures++;
                    $display("%0t: mismatch expected r=%0d g=%0d b=%0d (%0d,%0d) last=%0b done=%0b",
                             $realtime, want.red, want.green, want.blue, want.row, want.col,
                             want.last, want.done);
                    $display("%0t:          actual   r=%0d g=%0d b=%0d (%0d,%0d) last=%0b done=%0b",
                             $realtime, got.red, got.green, got.blue, got.row, got.col,
                             got.last, got.done);
                end
            end
        end
    end

    // Drive result-side backpressure, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            m_tready = !((idle_mode == 0 && $urandom_range(0, 99) < 73) ||
                         (idle_mode == 1 && $urandom_range(0, 99) < 12));
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int start_items;
        int kr;
        int kc;
        int w;
        int h;
        int frame_len;
        pixel_result_t typed_res;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_NONE;
        cfg_we      = 1'b0;
        cfg_index   = REG_KERNEL_ROWS;
        cfg_data    = '0;
        failures    = 0;
        idle_mode   = 0;
        long_hold   = 1'b0;
        total_items = 0;
        idle_cycles = 0;
        cur_row     = 0;
        cur_col     = 0;
        reg_kr      = 1;
        reg_kc      = 1;
        reg_w       = 640;
        reg_h       = 480;
        foreach (coef_mem[i])
        begin
            coef_mem[i]     = 0;
            coef_written[i] = 1'b0;
        end
        foreach (line_mem[a, b, ch])
            line_mem[a][b][ch] = 8'd0;

        // Reset defaults give a 1x1 kernel; then passthrough on a 2x1 image
        directed.push_back('{0, 0, 0, OP_LOAD, 0, COEF_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 255, 255, 255,
                             1, 130559, 130559, 130559, 0, 0, 1, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 0});
        directed.push_back('{0, 0, 0, OP_NONE, 77, 5, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_LOAD, 255, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_LOAD, 0, COEF_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 255, 0, 128,
                             1, -130560, 0, -65536, 0, 2, 1, 0});
        directed.push_back('{0, 0, 0, OP_PAD, 0, 0, 200, 200, 200, 1, 0, 0, 0, 0, 3, 1, 0});
        directed.push_back('{0, 0, 0, OP_LOAD, 224, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_LOAD, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 1, 2, 3, 1, 256, 512, 768, 0, 4, 1, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 170, 85, 240, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{1, REG_KERNEL_ROWS, 0, OP_NONE, 0, 0, 0, 0, 0,
                             0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{1, REG_IMAGE_WIDTH, 2, OP_NONE, 0, 0, 0, 0, 0,
                             0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{1, REG_IMAGE_HEIGHT, 0, OP_NONE, 0, 0, 0, 0, 0,
                             0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 255, 128, 1,
                             1, 65280, 32768, 256, 0, 0, 1, 0});
        directed.push_back('{0, 0, 0, OP_PAD, 0, 0, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1});
        directed.push_back('{0, 0, 0, OP_PIXEL, 0, 0, 7, 7, 7, 1, 1792, 1792, 1792, 0, 0, 1, 0});

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed[i].reg_idx, directed[i].value);
            end
            else
            begin
                send_request(directed[i].op, directed[i].coef_idx, directed[i].coef,
                             directed[i].red, directed[i].green, directed[i].blue);
                if (directed[i].typed)
                begin
                    void'(expected_q.pop_back());
                    typed_res.red   = directed[i].exp_red[23:0];
                    typed_res.green = directed[i].exp_green[23:0];
                    typed_res.blue  = directed[i].exp_blue[23:0];
                    typed_res.row   = directed[i].exp_row[9:0];
                    typed_res.col   = directed[i].exp_col[9:0];
                    typed_res.last  = directed[i].exp_last;
                    typed_res.done  = directed[i].exp_done;
                    expected_q.push_back(typed_res);
                end
            end
        end

        // Full-scale 9x9: positive clip at the center, then negative clip after a reload
        set_geometry(9, 9, 9, 9);
        load_kernel(1'b1, COEF_MAX);
        stream_frame(81, 1'b0, 1'b1);
        load_kernel(1'b1, COEF_MIN);
        stream_frame(36, 1'b0, 1'b0);

        // Tallest kernel, widest kernel (eight results per row end), single-column image, oversized height
        set_geometry(15, 1, 5, 2);
        load_kernel(1'b0, 0);
        stream_frame(45, 1'b1, 1'b0);
        set_geometry(1, 15, 8, 3);
        load_kernel(1'b0, 0);
        stream_frame(24, 1'b1, 1'b0);
        set_geometry(3, 5, 0, 4);
        load_kernel(1'b0, 0);
        stream_frame(12, 1'b1, 1'b0);
        set_geometry(3, 3, 1024, 2047);
        load_kernel(1'b0, 0);
        stream_frame(40, 1'b1, 1'b0);

        // Random frames over random geometry; stall the result side hard once
        start_items = total_items;
        long_hold   = 1'b1;
        while (total_items - start_items < 230)
        begin
            idle_mode = (total_items - start_items) * 3 / 230;
            kr = ($urandom_range(0, 9) < 8) ? 2 * $urandom_range(0, 2) + 1
                                            : 2 * $urandom_range(0, 7);
            kc = ($urandom_range(0, 9) < 8) ? 2 * $urandom_range(0, 2) + 1
                                            : 2 * $urandom_range(0, 7);
            w  = $urandom_range(1, 8);
            h  = $urandom_range(1, 6);
            set_geometry(kr, kc, w, h);
            if (kr % 2 == 1 && kc % 2 == 1)
            begin
                load_kernel(1'b0, 0);
                frame_len = (h + (kr - 1) / 2) * w;
            end
            else
                frame_len = h * w;
            if ($urandom_range(0, 3) == 0)
                stream_frame($urandom_range(1, frame_len), 1'b1, 1'b0);
            else
                stream_frame(frame_len * $urandom_range(1, 2), 1'b1, 1'b0);
        end

        wait_drained();
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
